FILE: rtl/core/lqm_pkg.sv
// Shared types, field widths and command/status codes of the linked queue manager.
// Used by lqm_ctrl and linked_queue_manager_top; depends on nothing else.
`default_nettype none

package lqm_pkg;

  // Fixed field widths of the stream words.
  localparam int CMD_W      = 2;
  localparam int QID_W      = 2;
  localparam int ELEM_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Default sizes of the element pool and of the queue set.
  localparam int LQM_NUM_ELEMENTS = 64;
  localparam int LQM_NUM_QUEUES   = 4;

  // Command codes. Any other code behaves as a query.
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  // One request as it arrives on the input stream.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [QID_W-1:0]  queue_id;
    logic [ELEM_W-1:0] element;
  } lqm_req_t;

  // One result as it leaves on the output stream.
  typedef struct packed {
    logic [ELEM_W-1:0]   taken_element;
    logic [COUNT_W-1:0]  queue_count;
    logic [ELEM_W-1:0]   head_element;
    logic [STATUS_W-1:0] status;
  } lqm_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/lqm_ctrl.sv
// Sequencer and storage of the linked queue manager: element link memory, queue memory,
// the read-modify-write steps of append, remove and query, and the clearing pass.
// Depends on lqm_pkg.
`default_nettype none

module lqm_ctrl #(
  parameter int NUM_ELEMENTS = lqm_pkg::LQM_NUM_ELEMENTS,
  parameter int NUM_QUEUES   = lqm_pkg::LQM_NUM_QUEUES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire lqm_pkg::lqm_req_t req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output lqm_pkg::lqm_res_t     res
);

  import lqm_pkg::*;

  localparam int EW        = $clog2(NUM_ELEMENTS);
  localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW        = $clog2(NUM_ELEMENTS + 1);
  localparam int CLR_DEPTH = (NUM_ELEMENTS > NUM_QUEUES) ? NUM_ELEMENTS : NUM_QUEUES;
  localparam int CLW       = $clog2(CLR_DEPTH);
  localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_DEPTH - 1);

  // One entry per element: membership, owning queue and both links.
  typedef struct packed {
    logic          inq;
    logic [QW-1:0] owner;
    logic [EW-1:0] nxt;
    logic [EW-1:0] prv;
  } ent_t;

  // One entry per queue: head element and member count.
  typedef struct packed {
    logic [EW-1:0] head;
    logic [CW-1:0] count;
  } qent_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_MOD_A,
    S_RD_B,
    S_MOD_B,
    S_WR_E,
    S_DONE
  } state_t;

  // Input values reduced into the element and queue ranges.
  logic [EW-1:0] elem_map [2**ELEM_W];
  logic [QW-1:0] qid_map  [2**QID_W];

  for (genvar g = 0; g < 2**ELEM_W; g++) begin : g_emap
    localparam int unsigned EMOD = g % NUM_ELEMENTS;
    assign elem_map[g] = EW'(EMOD);
  end

  for (genvar g = 0; g < 2**QID_W; g++) begin : g_qmap
    localparam int unsigned QMOD = g % NUM_QUEUES;
    assign qid_map[g] = QW'(QMOD);
  end

  // Memories and their ports.
  ent_t  emem [NUM_ELEMENTS];
  qent_t qmem [NUM_QUEUES];

  logic          em_we;
  logic [EW-1:0] em_addr;
  ent_t          em_wdata;
  ent_t          em_rdata_r;
  logic          qm_we;
  logic [QW-1:0] qm_addr;
  qent_t         qm_wdata;
  qent_t         qm_rdata_r;

  // Sequencer registers.
  state_t        state_r, state_nxt;
  logic [CLW-1:0] clr_idx_r, clr_idx_nxt;
  logic [CMD_W-1:0] op_r, op_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [EW-1:0] qh_r, qh_nxt;
  logic [CW-1:0] qc_r, qc_nxt;
  logic [EW-1:0] a_r, a_nxt;
  logic [EW-1:0] b_r, b_nxt;
  lqm_res_t      res_r, res_nxt;

  // Element memory: one access per cycle, write or registered read.
  always_ff @(posedge clk) begin
    if (em_we) begin
      emem[em_addr] <= em_wdata;
    end else begin
      em_rdata_r <= emem[em_addr];
    end
  end

  // Queue memory: same single-port form.
  always_ff @(posedge clk) begin
    if (qm_we) begin
      qmem[qm_addr] <= qm_wdata;
    end else begin
      qm_rdata_r <= qmem[qm_addr];
    end
  end

  // Step logic: memory accesses and next register values per state.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    op_nxt      = op_r;
    q_nxt       = q_r;
    e_nxt       = e_r;
    qh_nxt      = qh_r;
    qc_nxt      = qc_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    res_nxt     = res_r;
    em_we       = 1'b0;
    em_addr     = e_r;
    em_wdata    = em_rdata_r;
    qm_we       = 1'b0;
    qm_addr     = q_r;
    qm_wdata    = qm_rdata_r;

    case (state_r)
      // Sweep both memories once after reset.
      S_CLEAR: begin
        em_addr  = clr_idx_r[EW-1:0];
        em_wdata = '0;
        em_we    = ({1'b0, clr_idx_r} < (CLW + 1)'(NUM_ELEMENTS));
        qm_addr  = clr_idx_r[QW-1:0];
        qm_wdata = '0;
        qm_we    = ({1'b0, clr_idx_r} < (CLW + 1)'(NUM_QUEUES));
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
        clr_idx_nxt = clr_idx_r + CLW'(1);
      end

      // Read the element entry and the queue entry as the word is taken.
      S_IDLE: begin
        em_addr = elem_map[req.element];
        qm_addr = qid_map[req.queue_id];
        if (req_valid) begin
          op_nxt    = req.command;
          q_nxt     = qid_map[req.queue_id];
          e_nxt     = elem_map[req.element];
          state_nxt = S_EVAL;
        end
      end

      // Decide the operation from membership and queue count.
      S_EVAL: begin
        qh_nxt = qm_rdata_r.head;
        qc_nxt = qm_rdata_r.count;
        res_nxt.status        = ST_OK;
        res_nxt.head_element  = (qm_rdata_r.count != '0) ? ELEM_W'(qm_rdata_r.head) : '0;
        res_nxt.queue_count   = COUNT_W'(qm_rdata_r.count);
        res_nxt.taken_element = '0;
        state_nxt = S_DONE;
        case (op_r)
          CMD_APPEND: begin
            if (em_rdata_r.inq) begin
              res_nxt.status = ST_QUEUED;
            end else if (qm_rdata_r.count == '0) begin
              // First member links to itself.
              em_we    = 1'b1;
              em_addr  = e_r;
              em_wdata = '{inq: 1'b1, owner: q_r, nxt: e_r, prv: e_r};
              qm_we    = 1'b1;
              qm_wdata = '{head: e_r, count: CW'(1)};
              res_nxt.head_element = ELEM_W'(e_r);
              res_nxt.queue_count  = COUNT_W'(1);
            end else begin
              em_addr   = qm_rdata_r.head;
              a_nxt     = qm_rdata_r.head;
              state_nxt = S_MOD_A;
            end
          end
          CMD_REMOVE: begin
            if (qm_rdata_r.count == '0) begin
              res_nxt.status = ST_EMPTY;
            end else if (!em_rdata_r.inq || (em_rdata_r.owner != q_r)) begin
              res_nxt.status = ST_ABSENT;
            end else if (qm_rdata_r.count == CW'(1)) begin
              // Last member leaves; its links no longer matter.
              em_we    = 1'b1;
              em_addr  = e_r;
              em_wdata = '{inq: 1'b0, owner: q_r, nxt: e_r, prv: e_r};
              qm_we    = 1'b1;
              qm_wdata = '{head: qm_rdata_r.head, count: '0};
              res_nxt.head_element  = '0;
              res_nxt.queue_count   = '0;
              res_nxt.taken_element = ELEM_W'(e_r);
            end else begin
              em_addr   = em_rdata_r.prv;
              a_nxt     = em_rdata_r.prv;
              b_nxt     = em_rdata_r.nxt;
              state_nxt = S_MOD_A;
            end
          end
          default: begin
          end
        endcase
      end

      // First neighbor: the head on append, the predecessor on remove.
      S_MOD_A: begin
        em_we   = 1'b1;
        em_addr = a_r;
        if (op_r == CMD_APPEND) begin
          b_nxt    = em_rdata_r.prv;
          em_wdata = '{inq: em_rdata_r.inq, owner: em_rdata_r.owner,
                       nxt: (em_rdata_r.prv == a_r) ? e_r : em_rdata_r.nxt,
                       prv: e_r};
          state_nxt = (em_rdata_r.prv == a_r) ? S_WR_E : S_RD_B;
        end else begin
          em_wdata = '{inq: em_rdata_r.inq, owner: em_rdata_r.owner,
                       nxt: b_r,
                       prv: (a_r == b_r) ? a_r : em_rdata_r.prv};
          state_nxt = (a_r == b_r) ? S_WR_E : S_RD_B;
        end
      end

      // Second neighbor: the tail on append, the successor on remove.
      S_RD_B: begin
        em_addr   = b_r;
        state_nxt = S_MOD_B;
      end

      S_MOD_B: begin
        em_we   = 1'b1;
        em_addr = b_r;
        if (op_r == CMD_APPEND) begin
          em_wdata = '{inq: em_rdata_r.inq, owner: em_rdata_r.owner,
                       nxt: e_r, prv: em_rdata_r.prv};
        end else begin
          em_wdata = '{inq: em_rdata_r.inq, owner: em_rdata_r.owner,
                       nxt: em_rdata_r.nxt, prv: a_r};
        end
        state_nxt = S_WR_E;
      end

      // Element entry itself and the queue entry.
      S_WR_E: begin
        em_we   = 1'b1;
        em_addr = e_r;
        qm_we   = 1'b1;
        qm_addr = q_r;
        res_nxt.status = ST_OK;
        if (op_r == CMD_APPEND) begin
          em_wdata = '{inq: 1'b1, owner: q_r, nxt: qh_r, prv: b_r};
          qm_wdata = '{head: qh_r, count: qc_r + CW'(1)};
          res_nxt.head_element  = ELEM_W'(qh_r);
          res_nxt.queue_count   = COUNT_W'(qc_r + CW'(1));
          res_nxt.taken_element = '0;
        end else begin
          em_wdata = '{inq: 1'b0, owner: q_r, nxt: b_r, prv: a_r};
          qm_wdata = '{head: (qh_r == e_r) ? b_r : qh_r, count: qc_r - CW'(1)};
          res_nxt.head_element  = ELEM_W'((qh_r == e_r) ? b_r : qh_r);
          res_nxt.queue_count   = COUNT_W'(qc_r - CW'(1));
          res_nxt.taken_element = ELEM_W'(e_r);
        end
        state_nxt = S_DONE;
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      op_r      <= op_nxt;
      q_r       <= q_nxt;
      e_r       <= e_nxt;
      qh_r      <= qh_nxt;
      qc_r      <= qc_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      res_r     <= res_nxt;
    end
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire

FILE: rtl/core/linked_queue_manager_top.sv
// Top level of the linked queue manager: stream ports, word unpacking and the result register.
// Depends on lqm_pkg and lqm_ctrl.
//
// Usage. Each word on the in_ stream is one command: append an element at the tail of a
// queue, remove an element from a queue, or query a queue. Each command gives exactly one
// word on the out_ stream with a status, the queue's head and count after the command and
// the removed element on a successful remove.
// Timing. The time per append or remove is set by the single port of the element link
// memory: a full append or remove reads and rewrites the entries of two neighbors and then
// writes the element's own entry, one access per cycle. A new word is taken only after the
// result of the one before has moved to the output register.
// Reset. After rst_n is released a clearing pass over every entry of both memories empties
// all queues; in_tready stays low during the pass.
// Stall. The output register holds a result while out_tready is low; the next command is
// still taken and worked on, and waits at its end until the register is free.
`default_nettype none

module linked_queue_manager_top #(
  parameter int NUM_ELEMENTS = lqm_pkg::LQM_NUM_ELEMENTS,
  parameter int NUM_QUEUES   = lqm_pkg::LQM_NUM_QUEUES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // command [1:0], queue_id [3:2], element [9:4], zero [15:10]
  input  wire logic [lqm_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status [1:0], head_element [7:2], queue_count [14:8], taken_element [20:15],
  // zero [23:21]
  output logic [lqm_pkg::OUT_DATA_W-1:0]        out_tdata
);

  import lqm_pkg::*;

  lqm_req_t req;
  lqm_res_t res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_r;
  lqm_res_t out_res_r;

  // Unpack the input word.
  assign req.command  = in_tdata[CMD_W-1:0];
  assign req.queue_id = in_tdata[CMD_W +: QID_W];
  assign req.element  = in_tdata[CMD_W + QID_W +: ELEM_W];

  lqm_ctrl #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .NUM_QUEUES   (NUM_QUEUES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads when empty or when its word is being taken.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.taken_element, out_res_r.queue_count,
                       out_res_r.head_element, out_res_r.status};

`ifndef NO_ASSERTIONS
  // A taken element appears only with a successful remove.
  a_taken_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.taken_element != '0)) |-> (out_res_r.status == ST_OK))
    else $error("taken element reported on a failed operation");

  // An empty-queue status always reports a zero count.
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == ST_EMPTY)) |-> (out_res_r.queue_count == '0))
    else $error("empty status with nonzero count");

  // An empty queue reports head zero.
  a_head_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.queue_count == '0)) |-> (out_res_r.head_element == '0))
    else $error("nonzero head on an empty queue");

  // A queue never holds more elements than the pool.
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({25'd0, out_res_r.queue_count} <= 32'(NUM_ELEMENTS)))
    else $error("queue count beyond pool size");
`endif

endmodule

`default_nettype wire
